// ----- sv/binary_min_heap_queue_assert.svh -----
// assertion macros for the heap queue
// no dependencies; taken in by the top level
`ifndef BINARY_MIN_HEAP_QUEUE_ASSERT_SVH
`define BINARY_MIN_HEAP_QUEUE_ASSERT_SVH
`ifndef SYNTHESIS
`define BHQ_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("bhq assertion failed");
`define BHQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bhq assertion failed");
`else
`define BHQ_ASSERT(label, clk, rst_n, prop)
`define BHQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- sv/bhq_pkg.sv -----
// shared types and constants of the heap queue
// no dependencies
package bhq_pkg;

    localparam int CAPACITY_DEF = 1024;
    localparam int KEY_W        = 32;
    localparam int CMD_W        = 3;
    localparam int STATUS_W     = 2;
    localparam int FOUND_W      = 10;
    localparam int COUNT_W      = 11;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 3'd0,
        CMD_DELETE = 3'd1,
        CMD_SEARCH = 3'd2,
        CMD_APPEND = 3'd3,
        CMD_BUILD  = 3'd4
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK    = 2'd0,
        STS_FULL  = 2'd1,
        STS_EMPTY = 2'd2,
        STS_MISS  = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UP_RD,
        ST_UP_CMP,
        ST_LD_RD,
        ST_LD,
        ST_DN_RL,
        ST_DN_RR,
        ST_DN_SEL,
        ST_DN_CMP,
        ST_SR_RD,
        ST_SR_CMP,
        ST_DONE
    } t_state;

endpackage

// ----- sv/bhq_req_if.sv -----
// request channel of the heap queue
// depends on bhq_pkg
interface bhq_req_if;
    logic                                valid;
    logic                                ready;
    logic [bhq_pkg::CMD_W-1:0]           command;
    logic signed [bhq_pkg::KEY_W-1:0]    key;

    modport source (output valid, command, key, input ready);
    modport sink   (input valid, command, key, output ready);
endinterface

// ----- sv/bhq_rsp_if.sv -----
// response channel of the heap queue
// depends on bhq_pkg
interface bhq_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [bhq_pkg::STATUS_W-1:0]        status;
    logic [bhq_pkg::FOUND_W-1:0]         found_index;
    logic signed [bhq_pkg::KEY_W-1:0]    root_key;
    logic [bhq_pkg::COUNT_W-1:0]         entry_count;

    modport source (output valid, status, found_index, root_key, entry_count, input ready);
    modport sink   (input valid, status, found_index, root_key, entry_count, output ready);
endinterface

// ----- sv/bhq_mem.sv -----
// key store: one write port, one read port with registered data
// depends on bhq_pkg
module bhq_mem #(
    parameter int DEPTH = bhq_pkg::CAPACITY_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic [AW-1:0]                     i_waddr,
    input  logic signed [bhq_pkg::KEY_W-1:0]  i_wdata,
    input  logic                              i_re,
    input  logic [AW-1:0]                     i_raddr,
    output logic signed [bhq_pkg::KEY_W-1:0]  o_rdata
);
    logic signed [bhq_pkg::KEY_W-1:0] r_mem [DEPTH];
    logic signed [bhq_pkg::KEY_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- sv/bhq_cmp.sv -----
// shared key comparator: signed less-than and equality
// depends on bhq_pkg
module bhq_cmp (
    input  logic signed [bhq_pkg::KEY_W-1:0] i_a,
    input  logic signed [bhq_pkg::KEY_W-1:0] i_b,
    output logic                             o_lt,
    output logic                             o_eq
);
    assign o_lt = (i_a < i_b);
    assign o_eq = (i_a == i_b);
endmodule

// ----- sv/binary_min_heap_queue.sv -----
// binary min-heap queue: one request at a time, one response per request
// insert climbs one level at a time until the key is not smaller than its parent or reaches the root
// delete moves the last entry to the root and sifts it down level by level; search scans the entries in order
// build sifts down each subtree root in turn, from the last parent back to the root
// every step shares the single memory read port and the one shared comparator
// response sits in an output register; next request taken while it waits
// synchronous active-low reset empties the heap; store contents are not cleared
module binary_min_heap_queue #(
    parameter int CAPACITY = bhq_pkg::CAPACITY_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bhq_req_if.sink    i_req,
    bhq_rsp_if.source  o_rsp
);
    `include "binary_min_heap_queue_assert.svh"

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = CW + 1;

    // sequencer state
    bhq_pkg::t_state r_state, n_state;

    // entry count and work registers
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_pos, n_pos;       // hole position during a sift
    logic [CW-1:0] r_n, n_n;           // heap size used by sift down
    logic [CW-1:0] r_bi, n_bi;         // build: one past the next subtree root
    logic [CW-1:0] r_bidx, n_bidx;     // index of the smaller child
    logic [CW-1:0] r_found, n_found;
    logic          r_build, n_build;
    logic signed [bhq_pkg::KEY_W-1:0] r_cur, n_cur;    // key being moved
    logic signed [bhq_pkg::KEY_W-1:0] r_left, n_left;  // left child key
    logic signed [bhq_pkg::KEY_W-1:0] r_best, n_best;  // smaller child key
    logic signed [bhq_pkg::KEY_W-1:0] r_root;          // copy of entry zero
    bhq_pkg::t_status r_status, n_status;

    // response register
    logic                                r_ov;
    bhq_pkg::t_status                    r_o_status;
    logic [bhq_pkg::FOUND_W-1:0]         r_o_found;
    logic signed [bhq_pkg::KEY_W-1:0]    r_o_root;
    logic [bhq_pkg::COUNT_W-1:0]         r_o_count;

    // memory port
    logic                             mem_we, mem_re;
    logic [AW-1:0]                    mem_waddr, mem_raddr;
    logic signed [bhq_pkg::KEY_W-1:0] mem_wdata, mem_rdata;

    // comparator port
    logic signed [bhq_pkg::KEY_W-1:0] cmp_a, cmp_b;
    logic                             cmp_lt, cmp_eq;

    // derived indexes
    logic [XW-1:0] left_idx, right_idx, n_ext;
    logic [CW-1:0] parent_idx, bi_dec;
    logic          left_ok, right_ok, full, accept, out_free;
    bhq_pkg::t_cmd req_cmd;

    assign req_cmd    = bhq_pkg::t_cmd'(i_req.command);
    assign accept     = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == bhq_pkg::ST_IDLE);
    assign out_free   = !r_ov || o_rsp.ready;
    assign full       = (r_count == CW'(CAPACITY));
    assign left_idx   = {r_pos, 1'b1};
    assign right_idx  = left_idx + XW'(1);
    assign n_ext      = {1'b0, r_n};
    assign left_ok    = left_idx < n_ext;
    assign right_ok   = right_idx < n_ext;
    assign parent_idx = (r_pos - CW'(1)) >> 1;
    assign bi_dec     = r_bi - CW'(1);

    bhq_mem #(.DEPTH(CAPACITY), .AW(AW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    bhq_cmp u_cmp (
        .i_a  (cmp_a),
        .i_b  (cmp_b),
        .o_lt (cmp_lt),
        .o_eq (cmp_eq)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bhq_pkg::ST_IDLE: begin
                if (accept) begin
                    unique case (req_cmd)
                        bhq_pkg::CMD_INSERT: n_state = full ? bhq_pkg::ST_DONE
                                                            : bhq_pkg::ST_UP_RD;
                        bhq_pkg::CMD_DELETE: n_state = (r_count > CW'(1)) ? bhq_pkg::ST_LD
                                                                         : bhq_pkg::ST_DONE;
                        bhq_pkg::CMD_SEARCH: n_state = (r_count != '0) ? bhq_pkg::ST_SR_RD
                                                                      : bhq_pkg::ST_DONE;
                        bhq_pkg::CMD_BUILD:  n_state = (r_count > CW'(1)) ? bhq_pkg::ST_LD_RD
                                                                         : bhq_pkg::ST_DONE;
                        default:             n_state = bhq_pkg::ST_DONE;
                    endcase
                end
            end
            bhq_pkg::ST_UP_RD:  n_state = (r_pos == '0) ? bhq_pkg::ST_DONE : bhq_pkg::ST_UP_CMP;
            bhq_pkg::ST_UP_CMP: n_state = cmp_lt ? bhq_pkg::ST_UP_RD : bhq_pkg::ST_DONE;
            bhq_pkg::ST_LD_RD:  n_state = bhq_pkg::ST_LD;
            bhq_pkg::ST_LD:     n_state = bhq_pkg::ST_DN_RL;
            bhq_pkg::ST_DN_RL: begin
                if (left_ok) begin
                    n_state = bhq_pkg::ST_DN_RR;
                end else if (r_build && bi_dec != '0) begin
                    n_state = bhq_pkg::ST_LD_RD;
                end else begin
                    n_state = bhq_pkg::ST_DONE;
                end
            end
            bhq_pkg::ST_DN_RR:  n_state = bhq_pkg::ST_DN_SEL;
            bhq_pkg::ST_DN_SEL: n_state = bhq_pkg::ST_DN_CMP;
            bhq_pkg::ST_DN_CMP: begin
                if (cmp_lt) begin
                    n_state = bhq_pkg::ST_DN_RL;
                end else if (r_build && bi_dec != '0) begin
                    n_state = bhq_pkg::ST_LD_RD;
                end else begin
                    n_state = bhq_pkg::ST_DONE;
                end
            end
            bhq_pkg::ST_SR_RD:  n_state = bhq_pkg::ST_SR_CMP;
            bhq_pkg::ST_SR_CMP: begin
                if (cmp_eq || (r_pos + CW'(1)) >= r_count) begin
                    n_state = bhq_pkg::ST_DONE;
                end else begin
                    n_state = bhq_pkg::ST_SR_RD;
                end
            end
            bhq_pkg::ST_DONE:   n_state = out_free ? bhq_pkg::ST_IDLE : bhq_pkg::ST_DONE;
            default:            n_state = bhq_pkg::ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_count  = r_count;
        n_pos    = r_pos;
        n_n      = r_n;
        n_bi     = r_bi;
        n_bidx   = r_bidx;
        n_found  = r_found;
        n_build  = r_build;
        n_cur    = r_cur;
        n_left   = r_left;
        n_best   = r_best;
        n_status = r_status;
        mem_we    = 1'b0;
        mem_waddr = r_pos[AW-1:0];
        mem_wdata = r_cur;
        mem_re    = 1'b0;
        mem_raddr = r_pos[AW-1:0];
        cmp_a     = r_best;
        cmp_b     = r_cur;
        unique case (r_state)
            bhq_pkg::ST_IDLE: begin
                if (accept) begin
                    n_status = bhq_pkg::STS_OK;
                    n_found  = '0;
                    n_build  = 1'b0;
                    n_cur    = i_req.key;
                    n_pos    = r_count;
                    unique case (req_cmd)
                        bhq_pkg::CMD_INSERT: begin
                            if (full) begin
                                n_status = bhq_pkg::STS_FULL;
                            end else begin
                                n_count = r_count + CW'(1);
                            end
                        end
                        bhq_pkg::CMD_APPEND: begin
                            if (full) begin
                                n_status = bhq_pkg::STS_FULL;
                            end else begin
                                // raw append: store at the end, no reordering
                                n_count   = r_count + CW'(1);
                                mem_we    = 1'b1;
                                mem_waddr = r_count[AW-1:0];
                                mem_wdata = i_req.key;
                            end
                        end
                        bhq_pkg::CMD_DELETE: begin
                            if (r_count == '0) begin
                                n_status = bhq_pkg::STS_EMPTY;
                            end else begin
                                // last entry fills the hole at the root
                                n_count   = r_count - CW'(1);
                                n_n       = r_count - CW'(1);
                                n_pos     = '0;
                                mem_re    = 1'b1;
                                mem_raddr = n_n[AW-1:0];
                            end
                        end
                        bhq_pkg::CMD_SEARCH: begin
                            n_status = bhq_pkg::STS_MISS;
                            n_pos    = '0;
                        end
                        bhq_pkg::CMD_BUILD: begin
                            n_n     = r_count;
                            n_bi    = r_count >> 1;
                            n_build = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            bhq_pkg::ST_UP_RD: begin
                if (r_pos == '0) begin
                    mem_we = 1'b1;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = parent_idx[AW-1:0];
                end
            end
            bhq_pkg::ST_UP_CMP: begin
                cmp_a  = r_cur;
                cmp_b  = mem_rdata;
                mem_we = 1'b1;
                if (cmp_lt) begin
                    // parent moves down into the hole
                    mem_wdata = mem_rdata;
                    n_pos     = parent_idx;
                end
            end
            bhq_pkg::ST_LD_RD: begin
                mem_re    = 1'b1;
                mem_raddr = bi_dec[AW-1:0];
                n_pos     = bi_dec;
            end
            bhq_pkg::ST_LD: begin
                n_cur = mem_rdata;
            end
            bhq_pkg::ST_DN_RL: begin
                if (left_ok) begin
                    mem_re    = 1'b1;
                    mem_raddr = left_idx[AW-1:0];
                end else begin
                    mem_we = 1'b1;
                    n_bi   = bi_dec;
                end
            end
            bhq_pkg::ST_DN_RR: begin
                n_left = mem_rdata;
                if (right_ok) begin
                    mem_re    = 1'b1;
                    mem_raddr = right_idx[AW-1:0];
                end
            end
            bhq_pkg::ST_DN_SEL: begin
                // left child wins a tie
                cmp_a = mem_rdata;
                cmp_b = r_left;
                if (right_ok && cmp_lt) begin
                    n_best = mem_rdata;
                    n_bidx = right_idx[CW-1:0];
                end else begin
                    n_best = r_left;
                    n_bidx = left_idx[CW-1:0];
                end
            end
            bhq_pkg::ST_DN_CMP: begin
                cmp_a  = r_best;
                cmp_b  = r_cur;
                mem_we = 1'b1;
                if (cmp_lt) begin
                    mem_wdata = r_best;
                    n_pos     = r_bidx;
                end else begin
                    n_bi = bi_dec;
                end
            end
            bhq_pkg::ST_SR_RD: begin
                mem_re = 1'b1;
            end
            bhq_pkg::ST_SR_CMP: begin
                cmp_a = mem_rdata;
                cmp_b = r_cur;
                if (cmp_eq) begin
                    n_status = bhq_pkg::STS_OK;
                    n_found  = r_pos;
                end else begin
                    n_pos = r_pos + CW'(1);
                end
            end
            bhq_pkg::ST_DONE: ;
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bhq_pkg::ST_IDLE;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (r_state == bhq_pkg::ST_DONE && out_free) begin
                r_ov <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // work and response payload registers
    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_n      <= n_n;
        r_bi     <= n_bi;
        r_bidx   <= n_bidx;
        r_found  <= n_found;
        r_build  <= n_build;
        r_cur    <= n_cur;
        r_left   <= n_left;
        r_best   <= n_best;
        r_status <= n_status;
        // keep a copy of entry zero so the root is known without a read
        if (mem_we && mem_waddr == '0) begin
            r_root <= mem_wdata;
        end
        if (r_state == bhq_pkg::ST_DONE && out_free) begin
            r_o_status <= r_status;
            r_o_found  <= bhq_pkg::FOUND_W'(r_found);
            r_o_root   <= (r_count != '0) ? r_root : '0;
            r_o_count  <= bhq_pkg::COUNT_W'(r_count);
        end
    end

    assign o_rsp.valid       = r_ov;
    assign o_rsp.status      = r_o_status;
    assign o_rsp.found_index = r_o_found;
    assign o_rsp.root_key    = r_o_root;
    assign o_rsp.entry_count = r_o_count;

    // entry count never passes the capacity
    `BHQ_ASSERT(a_count_cap, i_clk, i_rst_n, r_count <= CW'(CAPACITY))
    // one request at a time: busy the cycle after a request is taken
    `BHQ_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, accept, !i_req.ready)
    // sift down always moves the hole to a deeper child
    `BHQ_ASSERT(a_child_deeper, i_clk, i_rst_n,
        (r_state != bhq_pkg::ST_DN_CMP) || (r_bidx > r_pos))
endmodule

// ----- tb/sv/binary_min_heap_queue_tb.sv -----
// self-checking testbench of the binary min-heap queue: random and directed requests
// depends on bhq_pkg, bhq_req_if, bhq_rsp_if and binary_min_heap_queue
`timescale 1ns / 100ps

module binary_min_heap_queue_tb;

    localparam int CAP = bhq_pkg::CAPACITY_DEF;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int FILL_N  = 300;
    localparam int DRAIN_N = 250;
    localparam int MIX_N   = 230;

    typedef struct packed {
        logic [bhq_pkg::CMD_W-1:0]        command;
        logic signed [bhq_pkg::KEY_W-1:0] key;
    } t_req;

    typedef struct packed {
        bhq_pkg::t_status                 status;
        logic [bhq_pkg::FOUND_W-1:0]      found_index;
        logic signed [bhq_pkg::KEY_W-1:0] root_key;
        logic [bhq_pkg::COUNT_W-1:0]      entry_count;
    } t_rsp;

    logic i_clk;
    logic i_rst_n;

    bhq_req_if req_ch ();
    bhq_rsp_if rsp_ch ();

    binary_min_heap_queue #(.CAPACITY(CAP)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    // shadow heap kept by the predictor
    logic signed [bhq_pkg::KEY_W-1:0] shadow_heap [CAP];
    int unsigned                      shadow_count;

    t_req pending_reqs [$];
    t_rsp expected_rsps [$];
    int   error_count = 0;
    int   cycle_count = 0;
    bit   stim_done = 1'b0;
    int   hold_off_cycles;   // long receiver stall, counted here

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------
    function automatic void heap_swap(int unsigned a, int unsigned b);
        logic signed [bhq_pkg::KEY_W-1:0] t;
        t = shadow_heap[a];
        shadow_heap[a] = shadow_heap[b];
        shadow_heap[b] = t;
    endfunction

    function automatic void heap_push_down(int unsigned pos, int unsigned cnt);
        int unsigned best;
        int unsigned lc;
        int unsigned rc;
        forever begin
            best = pos;
            lc = 2 * pos + 1;
            rc = 2 * pos + 2;
            if (lc < cnt && shadow_heap[lc] < shadow_heap[best]) best = lc;
            if (rc < cnt && shadow_heap[rc] < shadow_heap[best]) best = rc;
            if (best == pos) return;
            heap_swap(pos, best);
            pos = best;
        end
    endfunction

    function automatic t_rsp predict_heap_op(t_req r);
        t_rsp        p;
        int unsigned pos;
        int unsigned par;
        p = '0;
        p.status = bhq_pkg::STS_OK;
        case (r.command)
            bhq_pkg::CMD_INSERT, bhq_pkg::CMD_APPEND: begin
                if (shadow_count >= CAP) begin
                    p.status = bhq_pkg::STS_FULL;
                end else begin
                    shadow_heap[shadow_count] = r.key;
                    shadow_count++;
                    if (r.command == bhq_pkg::CMD_INSERT) begin
                        pos = shadow_count - 1;
                        while (pos > 0) begin
                            par = (pos - 1) / 2;
                            if (!(shadow_heap[pos] < shadow_heap[par])) break;
                            heap_swap(pos, par);
                            pos = par;
                        end
                    end
                end
            end
            bhq_pkg::CMD_DELETE: begin
                if (shadow_count == 0) begin
                    p.status = bhq_pkg::STS_EMPTY;
                end else begin
                    shadow_count--;
                    if (shadow_count > 0) begin
                        shadow_heap[0] = shadow_heap[shadow_count];
                        heap_push_down(0, shadow_count);
                    end
                end
            end
            bhq_pkg::CMD_SEARCH: begin
                p.status = bhq_pkg::STS_MISS;
                for (int unsigned i = 0; i < shadow_count; i++) begin
                    if (shadow_heap[i] == r.key) begin
                        p.status = bhq_pkg::STS_OK;
                        p.found_index = i[bhq_pkg::FOUND_W-1:0];
                        break;
                    end
                end
            end
            bhq_pkg::CMD_BUILD: begin
                for (int unsigned i = shadow_count / 2; i > 0; i--)
                    heap_push_down(i - 1, shadow_count);
            end
            default: ;  // unknown command reports state only
        endcase
        p.root_key    = shadow_count > 0 ? shadow_heap[0] : '0;
        p.entry_count = shadow_count[bhq_pkg::COUNT_W-1:0];
        return p;
    endfunction

    // ---------------------------------------------------------------
    // clock, reset, cycle limit
    // ---------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t timeout with %0d responses outstanding", $time,
                     expected_rsps.size());
            $display("binary_min_heap_queue verification failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------
    function automatic logic signed [bhq_pkg::KEY_W-1:0] pick_key();
        case ($urandom_range(0, 5))
            0:       return $urandom;
            1:       return 32'sh8000_0000 + $urandom_range(0, 3);
            2:       return 32'sh7fff_ffff - $urandom_range(0, 3);
            default: return $signed($urandom_range(0, 40)) - 20;  // many duplicates
        endcase
    endfunction

    task automatic queue_req(logic [bhq_pkg::CMD_W-1:0] c,
                             logic signed [bhq_pkg::KEY_W-1:0] k);
        pending_reqs.push_back('{command: c, key: k});
    endtask

    initial begin
        int roll;
        // directed: empty heap cases, extremes, duplicates, unknown codes
        queue_req(bhq_pkg::CMD_DELETE, 0);
        queue_req(bhq_pkg::CMD_SEARCH, 5);
        queue_req(bhq_pkg::CMD_BUILD, 0);
        queue_req(3'd7, 32'sh7fff_ffff);
        queue_req(bhq_pkg::CMD_INSERT, 32'sh7fff_ffff);
        queue_req(bhq_pkg::CMD_INSERT, 32'sh8000_0000);
        queue_req(bhq_pkg::CMD_INSERT, 0);
        queue_req(bhq_pkg::CMD_INSERT, -1);
        queue_req(bhq_pkg::CMD_INSERT, 0);
        queue_req(bhq_pkg::CMD_SEARCH, 0);
        queue_req(bhq_pkg::CMD_SEARCH, 32'sh7fff_ffff);
        queue_req(bhq_pkg::CMD_SEARCH, 12345);
        queue_req(bhq_pkg::CMD_APPEND, 32'sh8000_0000);  // appended key equals the root
        queue_req(bhq_pkg::CMD_APPEND, -5);
        queue_req(bhq_pkg::CMD_BUILD, 0);
        queue_req(3'd5, 0);
        queue_req(3'd6, 0);
        queue_req(bhq_pkg::CMD_DELETE, 0);
        queue_req(bhq_pkg::CMD_DELETE, 0);
        queue_req(bhq_pkg::CMD_SEARCH, 32'sh8000_0000);
        // grow a deep heap, reorder it, then drain most of it
        for (int i = 0; i < FILL_N; i++) begin
            queue_req($urandom_range(0, 3) == 0 ? bhq_pkg::CMD_APPEND : bhq_pkg::CMD_INSERT,
                      pick_key());
        end
        queue_req(bhq_pkg::CMD_INSERT, 1);
        queue_req(bhq_pkg::CMD_APPEND, 2);
        queue_req(bhq_pkg::CMD_SEARCH, pick_key());
        queue_req(bhq_pkg::CMD_BUILD, 0);
        for (int i = 0; i < DRAIN_N; i++) queue_req(bhq_pkg::CMD_DELETE, 0);
        // random mix
        for (int i = 0; i < MIX_N; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 30)      queue_req(bhq_pkg::CMD_INSERT, pick_key());
            else if (roll < 55) queue_req(bhq_pkg::CMD_DELETE, $urandom);
            else if (roll < 75) queue_req(bhq_pkg::CMD_SEARCH, pick_key());
            else if (roll < 88) queue_req(bhq_pkg::CMD_APPEND, pick_key());
            else if (roll < 96) queue_req(bhq_pkg::CMD_BUILD, $urandom);
            else                queue_req(bhq_pkg::CMD_W'($urandom_range(5, 7)), $urandom);
        end
    end

    // ---------------------------------------------------------------
    // driver: bursts and gaps
    // ---------------------------------------------------------------
    int gap_left;
    int burst_left;

    always @(posedge i_clk) begin
        t_req nxt;
        if (!i_rst_n) begin
            req_ch.valid   <= 1'b0;
            req_ch.command <= '0;
            req_ch.key     <= '0;
            gap_left       <= 0;
            burst_left     <= 0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                expected_rsps.push_back(predict_heap_op(
                    '{command: req_ch.command, key: req_ch.key}));
            end
            if (!req_ch.valid || req_ch.ready) begin
                if (gap_left > 0) begin
                    gap_left     <= gap_left - 1;
                    req_ch.valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    nxt = pending_reqs.pop_front();
                    req_ch.valid   <= 1'b1;
                    req_ch.command <= nxt.command;
                    req_ch.key     <= nxt.key;
                    if (burst_left > 0) begin
                        burst_left <= burst_left - 1;
                    end else begin
                        burst_left <= $urandom_range(0, 40);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
                    end
                end else begin
                    req_ch.valid <= 1'b0;
                    stim_done    <= 1'b1;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // monitor: receiver stalls, one long hold-off early on
    // ---------------------------------------------------------------
    int stall_phase;

    always @(posedge i_clk) begin
        t_rsp got;
        t_rsp exp_rsp;
        if (!i_rst_n) begin
            rsp_ch.ready    <= 1'b0;
            stall_phase     <= 0;
            hold_off_cycles <= 3000;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                got = '{status: bhq_pkg::t_status'(rsp_ch.status),
                        found_index: rsp_ch.found_index,
                        root_key: rsp_ch.root_key, entry_count: rsp_ch.entry_count};
                if (expected_rsps.size() == 0) begin
                    $display("%0t unexpected response expected none actual %p", $time, got);
                    error_count++;
                end else begin
                    exp_rsp = expected_rsps.pop_front();
                    if (got !== exp_rsp) begin
                        $display("%0t mismatch expected %p actual %p", $time, exp_rsp, got);
                        error_count++;
                    end
                end
            end
            stall_phase <= stall_phase + 1;
            if (cycle_count > 200 && hold_off_cycles > 0) begin
                hold_off_cycles <= hold_off_cycles - 1;
                rsp_ch.ready    <= 1'b0;
            end else if (stall_phase[9]) begin
                rsp_ch.ready <= 1'b1;  // stretch with no stalls
            end else begin
                rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    // ---------------------------------------------------------------
    // end of run
    // ---------------------------------------------------------------
    initial begin
        wait (stim_done);
        while (expected_rsps.size() > 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (error_count == 0) begin
            $display("binary_min_heap_queue verification clean");
        end else begin
            $display("binary_min_heap_queue verification failed");
        end
        $finish;
    end

endmodule
